FILE: rtl/core/assert_macros.svh
// Assertion macros for the queue RTL.
// Depends on nothing; included by spq_dp for its assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

FILE: rtl/core/spq_pkg.sv
// Types, codes and constants of the stable priority queue.
// Depends on nothing; used by spq_ctrl, spq_dp and the top level.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEF_CAPACITY = 128;
   localparam int ID_W         = 16;
   localparam int PAY_W        = 8;
   localparam int CNT_W        = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SERVE  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } st_type;

   localparam logic [1:0] PRIO_LOW = 2'd3;

   typedef enum logic [1:0] {
      RS_PTR,
      RS_PREV,
      RS_NEXT
   } rsel_type;

   typedef enum logic [1:0] {
      WS_NONE,
      WS_SHIFT,
      WS_NEW
   } wsel_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [2:0]       prio_in;
      logic [PAY_W-1:0] payload_in;
      logic [ID_W-1:0]  target_id;
   } req_type_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [ID_W-1:0]  entry_id;
      logic [1:0]       entry_prio;
      logic [PAY_W-1:0] entry_payload;
      logic             prio_replaced;
      logic [CNT_W-1:0] total_count;
      logic [CNT_W-1:0] level1_count;
      logic [CNT_W-1:0] level2_count;
      logic [CNT_W-1:0] level3_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [1:0]       prio;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic     capture;
      logic     ptr_set_occ;
      logic     ptr_clr;
      logic     ptr_dec;
      logic     ptr_inc;
      logic     rd_en;
      rsel_type rd_sel;
      wsel_type wr_sel;
      logic     hold_cap;
      logic     finish;
      st_type   res_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic ptr_zero;
      logic ptr_at_occ;
      logic ptr_last;
      logic prio_gt;
      logic match;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/spq_ctrl.sv
// Sequencer of the stable priority queue: walks insert, search and shift.
// Depends on spq_pkg; drives spq_dp through cmd_type, reads stat_type.
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_op,
   output logic             req_stall,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   st_type    res_ff, res_in;

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RS_PTR;
      cmd.wr_sel = WS_NONE;
      cmd.res_status = res_ff;
      state_in   = state_ff;
      res_in     = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               res_in      = ST_OK;
               unique case (req_op)
                  OP_INSERT: begin
                     cmd.ptr_set_occ = 1'b1;
                     if (stat.full) begin
                        res_in   = ST_FULL;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_SERVE: begin
                     cmd.ptr_clr = 1'b1;
                     if (stat.empty) begin
                        res_in   = ST_EMPTY;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  OP_REMOVE: begin
                     cmd.ptr_clr = 1'b1;
                     state_in    = S_SRCH_RD;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (stat.ptr_zero) begin
               cmd.wr_sel = WS_NEW;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RS_PREV;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (stat.prio_gt) begin
               cmd.wr_sel  = WS_SHIFT;
               cmd.ptr_dec = 1'b1;
               state_in    = S_INS_RD;
            end else begin
               cmd.wr_sel = WS_NEW;
               state_in   = S_FINISH;
            end
         end
         S_SRCH_RD: begin
            if (stat.ptr_at_occ) begin
               res_in   = ST_NOTFOUND;
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (stat.match) begin
               cmd.hold_cap = 1'b1;
               state_in     = S_SHIFT_RD;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.ptr_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RS_NEXT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_sel  = WS_SHIFT;
            cmd.ptr_inc = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule

FILE: rtl/core/spq_dp.sv
// Datapath of the stable priority queue: entry memory, pointer, counts, result.
// Depends on spq_pkg and assert_macros.svh; commanded by spq_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_dp #(
   parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::req_type_type req_payload,
   input  spq_pkg::cmd_type      cmd,
   output spq_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_type      rsp_payload
);
   import spq_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   entry_type       mem_ff [CAPACITY];
   entry_type       rd_ff;
   entry_type       hold_ff;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   occ_ff, occ_in;
   logic [CW-1:0]   lvl_ff [3];
   logic [CW-1:0]   lvl_in [3];
   logic [ID_W-1:0] nid_ff, nid_in;
   logic [1:0]      op_ff;
   logic [1:0]      prio_ff;
   logic            repl_ff;
   logic [PAY_W-1:0] pay_ff;
   logic [ID_W-1:0] tid_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [CW-1:0]   ptr_prev, ptr_next;
   logic [IW-1:0]   rd_addr;
   entry_type       new_entry;
   logic            commit, is_ins;
   logic [1:0]      cnt_prio;
   logic [1:0]      norm_prio;
   logic            norm_repl;
   rsp_type         res_in;

   assign ptr_prev = ptr_ff - 1'b1;
   assign ptr_next = ptr_ff + 1'b1;

   always_comb begin
      unique case (cmd.rd_sel)
         RS_PREV: rd_addr = ptr_prev[IW-1:0];
         RS_NEXT: rd_addr = ptr_next[IW-1:0];
         default: rd_addr = ptr_ff[IW-1:0];
      endcase
   end

   assign new_entry = '{id: nid_ff, prio: prio_ff, payload: pay_ff};

   // Entry memory: one write, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_sel == WS_SHIFT) begin
         mem_ff[ptr_ff[IW-1:0]] <= rd_ff;
      end else if (cmd.wr_sel == WS_NEW) begin
         mem_ff[ptr_ff[IW-1:0]] <= new_entry;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   // Invalid priorities fall back to the lowest level.
   always_comb begin
      if (req_payload.prio_in >= 3'd1 && req_payload.prio_in <= 3'd3) begin
         norm_prio = req_payload.prio_in[1:0];
         norm_repl = 1'b0;
      end else begin
         norm_prio = PRIO_LOW;
         norm_repl = 1'b1;
      end
   end

   always_comb begin
      stat.full       = (occ_ff >= CAP_CNT);
      stat.empty      = (occ_ff == '0);
      stat.ptr_zero   = (ptr_ff == '0);
      stat.ptr_at_occ = (ptr_ff == occ_ff);
      stat.ptr_last   = (({1'b0, ptr_ff} + 1'b1) == {1'b0, occ_ff});
      stat.prio_gt    = (rd_ff.prio > prio_ff);
      stat.match      = (op_ff == OP_SERVE) || (rd_ff.id == tid_ff);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign commit   = cmd.finish && (cmd.res_status == ST_OK) && (op_ff != OP_NONE);
   assign is_ins   = (op_ff == OP_INSERT);
   assign cnt_prio = is_ins ? prio_ff : hold_ff.prio;

   always_comb begin
      occ_in = occ_ff;
      nid_in = nid_ff;
      for (int k = 0; k < 3; k++) begin
         lvl_in[k] = lvl_ff[k];
      end
      if (commit) begin
         if (is_ins) begin
            occ_in = occ_ff + 1'b1;
            nid_in = nid_ff + 1'b1;
         end else begin
            occ_in = occ_ff - 1'b1;
         end
         for (int k = 0; k < 3; k++) begin
            if (cnt_prio == 2'(k + 1)) begin
               lvl_in[k] = is_ins ? lvl_ff[k] + 1'b1 : lvl_ff[k] - 1'b1;
            end
         end
      end
   end

   always_comb begin
      res_in               = '0;
      res_in.status        = cmd.res_status;
      res_in.total_count   = CNT_W'(occ_in);
      res_in.level1_count  = CNT_W'(lvl_in[0]);
      res_in.level2_count  = CNT_W'(lvl_in[1]);
      res_in.level3_count  = CNT_W'(lvl_in[2]);
      if (commit) begin
         if (is_ins) begin
            res_in.entry_id      = nid_ff;
            res_in.entry_prio    = prio_ff;
            res_in.entry_payload = pay_ff;
            res_in.prio_replaced = repl_ff;
         end else begin
            res_in.entry_id      = hold_ff.id;
            res_in.entry_prio    = hold_ff.prio;
            res_in.entry_payload = hold_ff.payload;
         end
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_set_occ) begin
         ptr_in = occ_ff;
      end else if (cmd.ptr_clr) begin
         ptr_in = '0;
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_prev;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         occ_ff       <= '0;
         nid_ff       <= ID_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            lvl_ff[k] <= '0;
         end
      end else begin
         ptr_ff <= ptr_in;
         occ_ff <= occ_in;
         nid_ff <= nid_in;
         for (int k = 0; k < 3; k++) begin
            lvl_ff[k] <= lvl_in[k];
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_payload.req_type;
         prio_ff <= norm_prio;
         repl_ff <= norm_repl;
         pay_ff  <= req_payload.payload_in;
         tid_ff  <= req_payload.target_id;
      end
      if (cmd.hold_cap) begin
         hold_ff <= rd_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SPQ_ASSERT_NOW(a_count_sum, clock, reset, 1'b1,
      ((CW + 2)'(lvl_ff[0]) + (CW + 2)'(lvl_ff[1]) + (CW + 2)'(lvl_ff[2])) == (CW + 2)'(occ_ff))
   `SPQ_ASSERT_NOW(a_write_in_range, clock, reset, cmd.wr_sel != WS_NONE,
      ptr_ff <= occ_ff && occ_ff <= CAP_CNT)
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, commit && is_ins,
      occ_ff == $past(occ_ff) + 1'b1)

endmodule

FILE: rtl/core/stable_three_level_priority_queue.sv
// Top level of the stable three-level priority queue.
// Depends on spq_pkg, spq_ctrl and spq_dp.
`timescale 1ns / 1ps

// Bounded queue of up to CAPACITY entries, each holding a 16-bit sequence id,
// a priority (1 most urgent, 3 least) and an 8-bit payload, kept sorted by
// priority with arrival order preserved inside a level. One transaction on
// req_ carries an operation: insert (invalid priorities become 3, the next id
// is assigned), serve the head, or remove the first entry with a given id.
// Every operation returns exactly one rsp_ transaction with a status code,
// the affected entry and the per-level and total counts after the operation.
// Entries live in a single-port-style memory (one write, one registered read
// per cycle), and inserts and removals move entries one at a time, so how
// long an operation takes depends on the occupancy and on the position of the
// entry. An insert reads back from the tail, moving each entry of lower
// urgency back one slot, then writes the new entry; a serve or remove
// searches from the head, then moves every entry behind the match forward one
// slot, and a remove whose id is absent reports it as not found. Full, empty
// and unused codes finish without touching the memory. A result is only
// presented once the previous one has been taken. The memory needs no
// clearing after reset; only entries below the occupancy are ever read.

module stable_three_level_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_type_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_type      rsp_payload
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: accept a transaction only when idle, then step the datapath.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: hold entries, counts and the result register.
   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
